@@ hdl/bmirq_pkg.sv @@
package bmirq_pkg;

    // Bus event kinds carried on the input tuser.
    localparam logic [1:0] CMD_CPU_WRITE = 2'd0;
    localparam logic [1:0] CMD_CPU_READ  = 2'd1;
    localparam logic [1:0] CMD_PPU       = 2'd2;
    localparam logic [1:0] CMD_TICK      = 2'd3;

    // Result kinds carried on the output tuser.
    localparam logic [2:0] SRC_NONE     = 3'd0;
    localparam logic [2:0] SRC_PRG_RAM  = 3'd1;
    localparam logic [2:0] SRC_PRG_ROM  = 3'd2;
    localparam logic [2:0] SRC_OPEN_BUS = 3'd3;
    localparam logic [2:0] SRC_PPU      = 3'd4;

    // Register selects held in the command latch.
    localparam logic [3:0] SEL_WINDOW   = 4'd8;
    localparam logic [3:0] SEL_PRG_8000 = 4'd9;
    localparam logic [3:0] SEL_PRG_A000 = 4'd10;
    localparam logic [3:0] SEL_PRG_C000 = 4'd11;
    localparam logic [3:0] SEL_MIRROR   = 4'd12;
    localparam logic [3:0] SEL_IRQ_CTRL = 4'd13;
    localparam logic [3:0] SEL_CNT_LO   = 4'd14;
    localparam logic [3:0] SEL_CNT_HI   = 4'd15;

    // Work RAM window modes.
    localparam logic [1:0] MODE_ROM = 2'd0;
    localparam logic [1:0] MODE_RAM = 2'd3;

    // Mirroring modes.
    localparam logic [1:0] MIR_VERTICAL   = 2'd0;
    localparam logic [1:0] MIR_HORIZONTAL = 2'd1;
    localparam logic [1:0] MIR_SINGLE_LO  = 2'd2;
    localparam logic [1:0] MIR_SINGLE_HI  = 2'd3;

    // CPU address pages (address bits 15:13).
    localparam logic [2:0] PAGE_6000 = 3'd3;
    localparam logic [2:0] PAGE_8000 = 3'd4;
    localparam logic [2:0] PAGE_A000 = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_CHR_IS_RAM    = 1'b0;
    localparam logic CFG_LAST_PRG_BANK = 1'b1;

    localparam int          WORK_RAM_BYTES_DEF = 8192;
    localparam logic [7:0]  LAST_PRG_RESET     = 8'd255;
    localparam logic [7:0]  PRG_C000_RESET     = LAST_PRG_RESET - 8'd1;

    // One result beat before packing.
    typedef struct packed {
        logic [2:0]  source;
        logic [7:0]  read_data;
        logic [20:0] prg_rom_address;
        logic [17:0] chr_address;
        logic [10:0] nametable_address;
        logic        irq_line;
    } t_result;

    // Work RAM access request from the mapper core.
    typedef struct packed {
        logic       wr;
        logic       rd;
        logic [7:0] wdata;
    } t_ram_req;

endpackage

@@ hdl/bank_mapper_with_irq_counter.sv @@
// Cartridge bank mapper with a down-counting cycle IRQ.
// Input beats (s_axis) carry one bus event: tuser is the event kind (CPU
// write, CPU read, PPU access, CPU cycle tick), tdata the address and the
// written byte. Every input beat yields exactly one output beat (m_axis):
// tuser says where the access goes, tdata holds the translated addresses,
// the read byte and the current IRQ level.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_index
// (0 = CHR is RAM, 1 = last PRG bank); the user must write only while no
// beat is in flight, as the block does not enforce it. An input beat passes
// the stage 1 register, where it meets the registered work RAM read, then
// the output register. Throughput is one beat per cycle while the receiver
// does not stall; the bank registers update on the accepting edge, so the
// next event sees them at once. After reset the 8 KiB work RAM is swept to
// zero, one byte per cycle; s_axis_tready stays low until the sweep ends.
// When the receiver stalls, the output register and the one stage behind
// it fill, then s_axis_tready drops; no beat is lost.
module bank_mapper_with_irq_counter
    import bmirq_pkg::*;
#(
    parameter int WORK_RAM_BYTES = WORK_RAM_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_wdata,
    // Bus events.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // address[15:0], data[23:16]
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    // Results.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0], prg_rom_address[28:8], chr_address[46:29],
    // nametable_address[57:47], irq_line[58], zero fill[63:59]
    output logic [63:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser    // source[2:0]
);

    localparam int AW = $clog2(WORK_RAM_BYTES);

    logic          r_chr_is_ram;
    logic [7:0]    r_last_prg;
    logic          r_s1_v;
    t_result       r_s1_res;
    logic          r_out_v;
    t_result       r_out_res;

    logic          in_fire;
    logic          s1_adv;
    logic          ram_busy;
    logic [7:0]    ram_rdata;
    t_result       core_res;
    t_result       s1_merged;
    t_ram_req      ram_req;
    logic [AW-1:0] ram_addr;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chr_is_ram <= 1'b0;
            r_last_prg   <= LAST_PRG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CHR_IS_RAM:    r_chr_is_ram <= i_cfg_wdata[0];
                CFG_LAST_PRG_BANK: r_last_prg   <= i_cfg_wdata;
                default:           r_last_prg   <= r_last_prg;
            endcase
        end
    end

    // Handshake: stage 1 moves to the output once the output register is free or read.
    assign s1_adv        = r_s1_v && (!r_out_v || m_axis_tready);
    assign s_axis_tready = !ram_busy && (!r_s1_v || s1_adv);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    bmirq_core #(
        .AW (AW)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (in_fire),
        .i_cmd           (s_axis_tuser),
        .i_addr          (s_axis_tdata[15:0]),
        .i_data          (s_axis_tdata[23:16]),
        .i_chr_is_ram    (r_chr_is_ram),
        .i_last_prg_bank (r_last_prg),
        .o_res           (core_res),
        .o_ram_req       (ram_req),
        .o_ram_addr      (ram_addr)
    );

    bmirq_ram #(
        .WORK_RAM_BYTES (WORK_RAM_BYTES),
        .AW             (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ram_req),
        .i_addr  (ram_addr),
        .o_rdata (ram_rdata),
        .o_busy  (ram_busy)
    );

    // Stage 1 and output register valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Merge the RAM byte into the stage 1 beat.
    always_comb begin
        s1_merged = r_s1_res;
        if (r_s1_res.source == SRC_PRG_RAM) begin
            s1_merged.read_data = ram_rdata;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_res <= core_res;
        end
        if (s1_adv) begin
            r_out_res <= s1_merged;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tuser  = r_out_res.source;
    assign m_axis_tdata  = {5'd0,
                            r_out_res.irq_line,
                            r_out_res.nametable_address,
                            r_out_res.chr_address,
                            r_out_res.prg_rom_address,
                            r_out_res.read_data};

`ifndef NO_ASSERTIONS
    a_no_accept_in_sweep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_busy |-> !in_fire)
        else $error("input beat accepted during work RAM sweep");
    a_accept_frees_s1 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> (!r_s1_v || s1_adv))
        else $error("input beat accepted over a held stage 1 beat");
    a_s1_held_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_out_v && !m_axis_tready) |=> r_s1_v)
        else $error("stage 1 beat dropped while output stalled");
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_v && !r_out_v))
        else $error("pipeline not empty after reset");
`endif

endmodule

@@ hdl/bmirq_ram.sv @@
module bmirq_ram
    import bmirq_pkg::*;
#(
    parameter int WORK_RAM_BYTES = WORK_RAM_BYTES_DEF,
    parameter int AW = $clog2(WORK_RAM_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ram_req      i_req,
    input  logic [AW-1:0] i_addr,
    output logic [7:0]    o_rdata,
    output logic          o_busy
);

    logic [7:0]    r_mem [WORK_RAM_BYTES];
    logic [7:0]    r_rdata;
    logic          r_busy;
    logic [AW-1:0] r_clr_addr;

    // Clearing sweep after reset: one byte per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(WORK_RAM_BYTES - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Single write port shared by the sweep and CPU writes.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= 8'd0;
        end else if (i_req.wr) begin
            r_mem[i_addr] <= i_req.wdata;
        end
    end

    // Registered read; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

@@ hdl/bmirq_core.sv @@
module bmirq_core
    import bmirq_pkg::*;
#(
    parameter int AW = $clog2(WORK_RAM_BYTES_DEF)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic [1:0]    i_cmd,
    input  logic [15:0]   i_addr,
    input  logic [7:0]    i_data,
    input  logic          i_chr_is_ram,
    input  logic [7:0]    i_last_prg_bank,
    output t_result       o_res,
    output t_ram_req      o_ram_req,
    output logic [AW-1:0] o_ram_addr
);

    logic [3:0]  r_cmd_latch, n_cmd_latch;
    logic [7:0]  r_chr_bank [8];
    logic [7:0]  n_chr_bank [8];
    logic [5:0]  r_low_bank, n_low_bank;
    logic [1:0]  r_ram_mode, n_ram_mode;
    logic [7:0]  r_prg_bank [3];
    logic [7:0]  n_prg_bank [3];
    logic [1:0]  r_mirror, n_mirror;
    logic [1:0]  r_irq_en, n_irq_en;
    logic [15:0] r_irq_cnt, n_irq_cnt;
    logic        r_irq_pend, n_irq_pend;

    logic [2:0]  page;
    logic [13:0] ppu_addr;
    logic [7:0]  rom_bank;
    logic        nt_page;

    assign page     = i_addr[15:13];
    assign ppu_addr = i_addr[13:0];

    // Next state for register writes and counter ticks.
    always_comb begin
        n_cmd_latch = r_cmd_latch;
        n_chr_bank  = r_chr_bank;
        n_low_bank  = r_low_bank;
        n_ram_mode  = r_ram_mode;
        n_prg_bank  = r_prg_bank;
        n_mirror    = r_mirror;
        n_irq_en    = r_irq_en;
        n_irq_cnt   = r_irq_cnt;
        n_irq_pend  = r_irq_pend;
        if (i_cmd == CMD_CPU_WRITE && page == PAGE_8000) begin
            n_cmd_latch = i_data[3:0];
        end else if (i_cmd == CMD_CPU_WRITE && page == PAGE_A000) begin
            case (r_cmd_latch) inside
                [4'd0:4'd7]: n_chr_bank[r_cmd_latch[2:0]] = i_data;
                SEL_WINDOW: begin
                    n_low_bank = i_data[5:0];
                    n_ram_mode = i_data[7:6];
                end
                SEL_PRG_8000: n_prg_bank[0] = i_data;
                SEL_PRG_A000: n_prg_bank[1] = i_data;
                SEL_PRG_C000: n_prg_bank[2] = i_data;
                SEL_MIRROR:   n_mirror = i_data[1:0];
                SEL_IRQ_CTRL: begin
                    // Writing the control register also acknowledges the IRQ.
                    n_irq_en   = {i_data[7], i_data[0]};
                    n_irq_pend = 1'b0;
                end
                SEL_CNT_LO: n_irq_cnt = {r_irq_cnt[15:8], i_data};
                default:    n_irq_cnt = {i_data, r_irq_cnt[7:0]};
            endcase
        end else if (i_cmd == CMD_TICK && r_irq_en[1]) begin
            n_irq_cnt = r_irq_cnt - 16'd1;
            if (r_irq_cnt == 16'd0 && r_irq_en[0]) begin
                n_irq_pend = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_latch <= '0;
            for (int i = 0; i < 8; i++) begin
                r_chr_bank[i] <= 8'(i);
            end
            r_low_bank    <= '0;
            r_ram_mode    <= MODE_ROM;
            r_prg_bank[0] <= 8'd0;
            r_prg_bank[1] <= 8'd1;
            r_prg_bank[2] <= PRG_C000_RESET;
            r_mirror      <= MIR_VERTICAL;
            r_irq_en      <= '0;
            r_irq_cnt     <= '0;
            r_irq_pend    <= 1'b0;
        end else if (i_fire) begin
            r_cmd_latch <= n_cmd_latch;
            r_chr_bank  <= n_chr_bank;
            r_low_bank  <= n_low_bank;
            r_ram_mode  <= n_ram_mode;
            r_prg_bank  <= n_prg_bank;
            r_mirror    <= n_mirror;
            r_irq_en    <= n_irq_en;
            r_irq_cnt   <= n_irq_cnt;
            r_irq_pend  <= n_irq_pend;
        end
    end

    // Work RAM access for the $6000 window in RAM mode.
    always_comb begin
        o_ram_req.wr    = i_fire && i_cmd == CMD_CPU_WRITE && page == PAGE_6000
                          && r_ram_mode == MODE_RAM;
        o_ram_req.rd    = i_fire && i_cmd == CMD_CPU_READ && page == PAGE_6000
                          && r_ram_mode == MODE_RAM;
        o_ram_req.wdata = i_data;
    end
    assign o_ram_addr = i_addr[AW-1:0];

    // PRG bank for a read at $8000 and above.
    always_comb begin
        case (i_addr[14:13])
            2'd0:    rom_bank = r_prg_bank[0];
            2'd1:    rom_bank = r_prg_bank[1];
            2'd2:    rom_bank = r_prg_bank[2];
            default: rom_bank = i_last_prg_bank;
        endcase
    end

    // Nametable page after mirroring.
    always_comb begin
        case (r_mirror)
            MIR_VERTICAL:   nt_page = ppu_addr[10];
            MIR_HORIZONTAL: nt_page = ppu_addr[11];
            MIR_SINGLE_LO:  nt_page = 1'b0;
            default:        nt_page = 1'b1;
        endcase
    end

    // Address translation for the result beat.
    always_comb begin
        o_res = '0;
        o_res.irq_line = n_irq_pend;
        if (i_cmd == CMD_CPU_READ) begin
            if (page == PAGE_6000) begin
                if (r_ram_mode == MODE_ROM) begin
                    o_res.source          = SRC_PRG_ROM;
                    o_res.prg_rom_address = {2'b00, r_low_bank, i_addr[12:0]};
                end else if (r_ram_mode == MODE_RAM) begin
                    // Byte itself comes from the registered RAM read, merged in at stage 1.
                    o_res.source = SRC_PRG_RAM;
                end else begin
                    o_res.source    = SRC_OPEN_BUS;
                    o_res.read_data = i_addr[15:8];
                end
            end else if (i_addr[15]) begin
                o_res.source          = SRC_PRG_ROM;
                o_res.prg_rom_address = {rom_bank, i_addr[12:0]};
            end
        end else if (i_cmd == CMD_PPU) begin
            o_res.source = SRC_PPU;
            if (!ppu_addr[13]) begin
                if (i_chr_is_ram) begin
                    o_res.chr_address = {5'd0, ppu_addr[12:0]};
                end else begin
                    o_res.chr_address = {r_chr_bank[ppu_addr[12:10]], ppu_addr[9:0]};
                end
            end else begin
                o_res.nametable_address = {nt_page, ppu_addr[9:0]};
            end
        end
    end

endmodule

@@ tb/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bmirq_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int PIPE_LATENCY  = 2;
    localparam int STALL_CYCLES  = 250;
    localparam int PHASE_ITEMS   = 400;
    localparam int STALL_ITEMS   = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [7:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    bank_mapper_with_irq_counter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Mapper state as the translation logic should see it.
    logic [3:0]  mp_command;
    logic [7:0]  mp_chr_bank [8];
    logic [5:0]  mp_window_bank;
    logic [1:0]  mp_ram_mode;
    logic [7:0]  mp_prg_bank [3];
    logic [1:0]  mp_mirror;
    logic [1:0]  mp_irq_ctrl;
    logic [15:0] mp_irq_counter;
    logic        mp_irq_pending;
    logic [7:0]  mp_work_ram [8192];
    logic        cfg_chr_ram;
    logic [7:0]  cfg_last_bank;

    t_result     expected_results [$];

    int          error_count = 0;
    int          items_sent = 0;
    int          results_checked = 0;
    int          irq_assertions = 0;
    int          cycle_count = 0;
    int          stall_requests = 0;
    int          stall_served = 0;
    int          hold_left = 0;
    logic        steady_stretch = 1'b0;

    // Clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run-length guard.
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $error("run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    // Restore the mapper state to its power-on values.
    task automatic reset_mapper_model();
        cfg_chr_ram    = 1'b0;
        cfg_last_bank  = LAST_PRG_RESET;
        mp_command     = '0;
        for (int i = 0; i < 8; i++) mp_chr_bank[i] = 8'(i);
        mp_window_bank = '0;
        mp_ram_mode    = MODE_ROM;
        mp_prg_bank[0] = 8'd0;
        mp_prg_bank[1] = 8'd1;
        mp_prg_bank[2] = LAST_PRG_RESET - 8'd1;
        mp_mirror      = MIR_VERTICAL;
        mp_irq_ctrl    = '0;
        mp_irq_counter = '0;
        mp_irq_pending = 1'b0;
        for (int i = 0; i < 8192; i++) mp_work_ram[i] = '0;
    endtask

    // Load the register picked by the command latch.
    task automatic load_selected_register(input logic [7:0] value);
        if (!mp_command[3]) begin
            mp_chr_bank[mp_command[2:0]] = value;
        end else begin
            case (mp_command)
                SEL_WINDOW: begin
                    mp_window_bank = value[5:0];
                    mp_ram_mode    = value[7:6];
                end
                SEL_PRG_8000: mp_prg_bank[0] = value;
                SEL_PRG_A000: mp_prg_bank[1] = value;
                SEL_PRG_C000: mp_prg_bank[2] = value;
                SEL_MIRROR:   mp_mirror = value[1:0];
                SEL_IRQ_CTRL: begin
                    // Any control write also acknowledges the interrupt.
                    mp_irq_ctrl    = {value[7], value[0]};
                    mp_irq_pending = 1'b0;
                end
                SEL_CNT_LO:   mp_irq_counter[7:0] = value;
                default:      mp_irq_counter[15:8] = value;
            endcase
        end
    endtask

    // Work out the result of one bus event and advance the mapper state.
    task automatic translate_bus_event(input logic [1:0] cmd, input logic [15:0] addr,
                                       input logic [7:0] data, output t_result res);
        logic [13:0] ppu_addr;
        logic [7:0]  bank;
        logic        page;
        logic        was_pending;
        res = '0;
        was_pending = mp_irq_pending;
        ppu_addr = addr[13:0];
        case (cmd)
            CMD_CPU_WRITE: begin
                if (addr[15:13] == PAGE_6000) begin
                    if (mp_ram_mode == MODE_RAM) mp_work_ram[addr[12:0]] = data;
                end else if (addr[15:13] == PAGE_8000) begin
                    mp_command = data[3:0];
                end else if (addr[15:13] == PAGE_A000) begin
                    load_selected_register(data);
                end
            end
            CMD_CPU_READ: begin
                if (addr[15:13] == PAGE_6000) begin
                    case (mp_ram_mode)
                        MODE_ROM: begin
                            res.source          = SRC_PRG_ROM;
                            res.prg_rom_address = {2'b00, mp_window_bank, addr[12:0]};
                        end
                        MODE_RAM: begin
                            res.source    = SRC_PRG_RAM;
                            res.read_data = mp_work_ram[addr[12:0]];
                        end
                        default: begin
                            res.source    = SRC_OPEN_BUS;
                            res.read_data = addr[15:8];
                        end
                    endcase
                end else if (addr[15]) begin
                    bank = (addr[14:13] == 2'b11) ? cfg_last_bank : mp_prg_bank[addr[14:13]];
                    res.source          = SRC_PRG_ROM;
                    res.prg_rom_address = {bank, addr[12:0]};
                end
            end
            CMD_PPU: begin
                res.source = SRC_PPU;
                if (!ppu_addr[13]) begin
                    if (cfg_chr_ram) res.chr_address = {5'b00000, ppu_addr[12:0]};
                    else res.chr_address = {mp_chr_bank[ppu_addr[12:10]], ppu_addr[9:0]};
                end else begin
                    case (mp_mirror)
                        MIR_VERTICAL:   page = ppu_addr[10];
                        MIR_HORIZONTAL: page = ppu_addr[11];
                        MIR_SINGLE_LO:  page = 1'b0;
                        default:        page = 1'b1;
                    endcase
                    res.nametable_address = {page, ppu_addr[9:0]};
                end
            end
            default: begin
                // The counter wraps from zero to all ones to raise the line.
                if (mp_irq_ctrl[1]) begin
                    mp_irq_counter = mp_irq_counter - 16'd1;
                    if (mp_irq_counter == 16'hFFFF && mp_irq_ctrl[0]) mp_irq_pending = 1'b1;
                end
            end
        endcase
        if (mp_irq_pending && !was_pending) irq_assertions++;
        res.irq_line = mp_irq_pending;
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            error_count++;
        end
    endtask

    // Predict on every accepted input beat and check every accepted output beat.
    always @(posedge i_clk) begin : scoreboard
        t_result predicted;
        t_result oldest;
        if (!i_rst_n) begin
            reset_mapper_model();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_CHR_IS_RAM) cfg_chr_ram = i_cfg_wdata[0];
                else cfg_last_bank = i_cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                translate_bus_event(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[23:16],
                                    predicted);
                expected_results.push_back(predicted);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat arrived with no bus event outstanding");
                    error_count++;
                end else begin
                    oldest = expected_results.pop_front();
                    compare_field("source", oldest.source, m_axis_tuser);
                    compare_field("read_data", oldest.read_data, m_axis_tdata[7:0]);
                    compare_field("prg_rom_address", oldest.prg_rom_address,
                                  m_axis_tdata[28:8]);
                    compare_field("chr_address", oldest.chr_address, m_axis_tdata[46:29]);
                    compare_field("nametable_address", oldest.nametable_address,
                                  m_axis_tdata[57:47]);
                    compare_field("irq_line", oldest.irq_line, m_axis_tdata[58]);
                    results_checked++;
                end
            end
        end
    end

    // Result-side readiness: random holds, a steady stretch, and requested long stalls.
    always @(posedge i_clk) begin
        if (stall_requests != stall_served) begin
            stall_served  <= stall_served + 1;
            hold_left     <= STALL_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady_stretch || ($urandom_range(0, 99) >= 13);
        end
    end

    // Offer one bus event and wait until it is taken.
    task automatic send_bus_event(input logic [1:0] cmd, input logic [15:0] addr,
                                  input logic [7:0] data);
        if (!steady_stretch) begin
            while ($urandom_range(0, 99) < 13) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {data, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Latch a register select, then load that register.
    task automatic program_mapper_register(input logic [3:0] sel, input logic [7:0] value);
        send_bus_event(CMD_CPU_WRITE, {PAGE_8000, 13'($urandom)}, {4'($urandom), sel});
        send_bus_event(CMD_CPU_WRITE, {PAGE_A000, 13'($urandom)}, value);
    endtask

    // Stop offering beats and wait for every outstanding result.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 1) @(posedge i_clk);
    endtask

    task automatic write_config(input logic index, input logic [7:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // One random, mostly well-formed piece of bus traffic.
    task automatic send_random_sequence();
        int          kind;
        logic [3:0]  sel;
        logic [7:0]  value;
        logic [12:0] offset;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            sel   = 4'($urandom);
            value = 8'($urandom);
            if (sel == SEL_CNT_HI && $urandom_range(0, 3) != 0) value = 8'd0;
            if (sel == SEL_CNT_LO && $urandom_range(0, 1) != 0) value = 8'($urandom_range(0, 15));
            if (sel == SEL_IRQ_CTRL)
                value = {1'($urandom_range(0, 9) < 7), 6'($urandom), 1'($urandom_range(0, 9) < 7)};
            if (sel == SEL_WINDOW && $urandom_range(0, 1) != 0) value[7:6] = MODE_RAM;
            program_mapper_register(sel, value);
        end else if (kind < 45) begin
            if ($urandom_range(0, 1) != 0)
                send_bus_event(CMD_CPU_READ, {PAGE_6000, 13'($urandom)}, 8'($urandom));
            else
                send_bus_event(CMD_CPU_READ, 16'($urandom), 8'($urandom));
        end else if (kind < 60) begin
            send_bus_event(CMD_PPU, 16'($urandom), 8'($urandom));
        end else if (kind < 78) begin
            repeat ($urandom_range(1, 12))
                send_bus_event(CMD_TICK, 16'($urandom), 8'($urandom));
        end else if (kind < 90) begin
            // Store to the low window, often read straight back.
            offset = 13'($urandom);
            send_bus_event(CMD_CPU_WRITE, {PAGE_6000, offset}, 8'($urandom));
            if ($urandom_range(0, 1) != 0)
                send_bus_event(CMD_CPU_READ, {PAGE_6000, offset}, 8'($urandom));
        end else begin
            send_bus_event(2'($urandom), 16'($urandom), 8'($urandom));
        end
    endtask

    // Power-on bank layout, unmapped reads and PPU address folding.
    task automatic test_reset_decode();
        send_bus_event(CMD_CPU_READ, 16'h0000, 8'hFF);
        send_bus_event(CMD_CPU_READ, 16'h8000, 8'h00);
        send_bus_event(CMD_CPU_READ, 16'hDFFF, 8'h00);
        send_bus_event(CMD_CPU_READ, 16'hFFFF, 8'h00);
        send_bus_event(CMD_PPU, 16'h0400, 8'h00);
        send_bus_event(CMD_PPU, 16'hFFFF, 8'hFF);
    endtask

    // Low window as work RAM, then as open bus; writes outside any register.
    task automatic test_work_ram_window();
        program_mapper_register(SEL_WINDOW, 8'hFF);
        send_bus_event(CMD_CPU_WRITE, 16'h7FFF, 8'hA5);
        send_bus_event(CMD_CPU_READ, 16'h7FFF, 8'h00);
        send_bus_event(CMD_CPU_READ, 16'h6001, 8'h00);
        send_bus_event(CMD_CPU_WRITE, 16'hC000, 8'h5A);
        program_mapper_register(SEL_WINDOW, 8'h7F);
        send_bus_event(CMD_CPU_READ, 16'h7ABC, 8'h00);
    endtask

    // Counter wrap raises the line, a control write clears it.
    task automatic test_irq_acknowledge();
        program_mapper_register(SEL_CNT_LO, 8'h01);
        program_mapper_register(SEL_IRQ_CTRL, 8'h81);
        send_bus_event(CMD_TICK, 16'h0000, 8'h00);
        send_bus_event(CMD_TICK, 16'hFFFF, 8'hFF);
        program_mapper_register(SEL_IRQ_CTRL, 8'h00);
    endtask

    // Changing the fixed bank moves $E000 only, not the $C000 bank.
    task automatic test_fixed_bank_config();
        write_config(CFG_LAST_PRG_BANK, 8'h00);
        send_bus_event(CMD_CPU_READ, 16'hC123, 8'h00);
        send_bus_event(CMD_CPU_READ, 16'hE456, 8'h00);
    endtask

    // Hold the result side off long enough for the input to back up.
    task automatic test_output_stall();
        int target;
        target = items_sent + STALL_ITEMS;
        stall_requests <= stall_requests + 1;
        while (items_sent < target) send_random_sequence();
    endtask

    // Random traffic under several configurations, extremes included.
    task automatic test_random_phases();
        int         target;
        logic [7:0] last_bank;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       last_bank = 8'hFF;
                1:       last_bank = 8'h00;
                default: last_bank = 8'($urandom_range(1, 254));
            endcase
            write_config(CFG_CHR_IS_RAM, {7'($urandom), 1'(phase % 2)});
            write_config(CFG_LAST_PRG_BANK, last_bank);
            steady_stretch <= (phase == 2);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                if (phase == 2 && items_sent > target - PHASE_ITEMS / 2) steady_stretch <= 1'b0;
                send_random_sequence();
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_decode();
        test_work_ram_window();
        test_irq_acknowledge();
        test_fixed_bank_config();
        test_output_stall();
        test_random_phases();

        drain_results();
        repeat (10) @(posedge i_clk);
        $display("Ran %0d bus events (%0d results checked) over four mapper configurations,",
                 items_sent, results_checked);
        $display("with %0d interrupt assertions and one long output stall.", irq_assertions);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
